// ----- rtl/eibs_pkg.sv -----
// Shared types, field widths and the popcount function of the edge bitmap table.
package eibs_pkg;

  localparam int WORD_BITS   = 64;
  localparam int WORD_IDX_W  = 6;
  localparam int POP_W       = 7;
  localparam int CMD_W       = 2;
  localparam int EDGE_W      = 6;
  localparam int VERTEX_W    = 10;
  localparam int COUNT_W     = 11;
  localparam int SUPPORT_W   = 10;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_TEST    = 2'd1,
    CMD_COUNT   = 2'd2,
    CMD_SUPPORT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_INS_WAIT,
    S_TEST_WAIT,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_t;

  function automatic logic [POP_W-1:0] pop64(input logic [WORD_BITS-1:0] w);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++) l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++) l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++) l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

endpackage

// ----- rtl/eibs_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module eibs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/edge_image_bitmap_support.sv -----
// Top level of the edge bitmap table: two endpoint banks, scan pipeline and result register.
//
// channel | dir | beat contents
// in_     | in  | tuser: cmd; tdata: edge_req, endpoint, vertex
// out_    | out | tdata: found, count, support
//
// Insert reads the word, sets the vertex bit and writes it back; test reads the word, then passes the result stage.
// Count and support scan the edge's row: one word of each bank per cycle.
// After reset a clearing pass writes zeros to EDGES*ROW_WORDS words of both banks in parallel;
// in_tready stays low until it ends.
// A stalled out_ channel holds the next result in its state until the output register frees.
module edge_image_bitmap_support #(
  parameter int EDGES    = 64,
  parameter int VERTICES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [eibs_pkg::IN_TDATA_W-1:0]   in_tdata,   // edge_req, endpoint, vertex, zero pad
  input  logic [eibs_pkg::CMD_W-1:0]        in_tuser,   // cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [eibs_pkg::OUT_TDATA_W-1:0]  out_tdata   // found, count, support, zero pad
);

  import eibs_pkg::*;

  localparam int ROW_WORDS = (VERTICES + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH     = EDGES * ROW_WORDS;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WC_W      = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int CNT_W     = $clog2(VERTICES + 1);

  state_t state_r, state_nxt;

  cmd_t                 cmd_r;
  logic [EDGE_W-1:0]    edge_r;
  logic                 ep_r;
  logic [VERTEX_W-1:0]  vertex_r;

  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [WC_W-1:0]      wcnt_r, wcnt_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic                 pop_v_r;
  logic [POP_W-1:0]     pop0_r, pop1_r, popu_r;
  logic [CNT_W-1:0]     acc0_r, acc1_r, accu_r;
  logic [CNT_W-1:0]     acc0_nxt, acc1_nxt, accu_nxt;

  logic                 res_found_r, res_found_nxt;
  logic [COUNT_W-1:0]   res_count_r, res_count_nxt;
  logic [SUPPORT_W-1:0] res_support_r, res_support_nxt;

  logic                 out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                 edge_ok, vtx_ok, item_ok, scan_last, out_free;
  logic [AW-1:0]        item_addr, scan_addr;
  logic [WORD_BITS-1:0] rdata0, rdata1, rdata_sel, wdata;
  logic                 re, we0, we1;
  logic [AW-1:0]        raddr, waddr;
  logic [CNT_W-1:0]     half_u, sup_min;

  assign edge_ok   = int'(edge_r) < EDGES;
  assign vtx_ok    = int'(vertex_r) < VERTICES;
  assign item_ok   = edge_ok && vtx_ok;
  assign item_addr = AW'(int'(edge_r) * ROW_WORDS + int'(vertex_r[VERTEX_W-1:WORD_IDX_W]));
  assign scan_addr = AW'(int'(edge_r) * ROW_WORDS + int'(wcnt_r));
  assign scan_last = (wcnt_r == WC_W'(ROW_WORDS - 1));
  assign out_free  = !out_tvalid_r || out_tready;
  assign rdata_sel = ep_r ? rdata1 : rdata0;
  assign half_u    = accu_r >> 1;
  assign sup_min   = (acc0_r < half_u) ? ((acc1_r < acc0_r) ? acc1_r : acc0_r)
                                       : ((acc1_r < half_u) ? acc1_r : half_u);

  eibs_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata0)
  );

  eibs_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata1)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_START;
      end
      S_START: begin
        case (cmd_r)
          CMD_INSERT:  state_nxt = item_ok ? S_INS_WAIT : S_IDLE;
          CMD_TEST:    state_nxt = item_ok ? S_TEST_WAIT : S_RESULT;
          CMD_COUNT:   state_nxt = edge_ok ? S_SCAN : S_RESULT;
          CMD_SUPPORT: state_nxt = edge_ok ? S_SCAN : S_RESULT;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_INS_WAIT:  state_nxt = S_IDLE;
      S_TEST_WAIT: state_nxt = S_RESULT;
      S_SCAN: begin
        if (scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!rd_v_r && !pop_v_r) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_tready       = 1'b0;
    re              = 1'b0;
    we0             = 1'b0;
    we1             = 1'b0;
    raddr           = item_addr;
    waddr           = item_addr;
    wdata           = '0;
    clr_addr_nxt    = clr_addr_r;
    wcnt_nxt        = wcnt_r;
    rd_v_nxt        = 1'b0;
    acc0_nxt        = acc0_r;
    acc1_nxt        = acc1_r;
    accu_nxt        = accu_r;
    res_found_nxt   = res_found_r;
    res_count_nxt   = res_count_r;
    res_support_nxt = res_support_r;
    if (pop_v_r) begin
      acc0_nxt = acc0_r + CNT_W'(pop0_r);
      acc1_nxt = acc1_r + CNT_W'(pop1_r);
      accu_nxt = accu_r + CNT_W'(popu_r);
    end
    case (state_r)
      S_CLEAR: begin
        we0          = 1'b1;
        we1          = 1'b1;
        waddr        = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_START: begin
        res_found_nxt   = 1'b0;
        res_count_nxt   = '0;
        res_support_nxt = '0;
        wcnt_nxt        = '0;
        acc0_nxt        = '0;
        acc1_nxt        = '0;
        accu_nxt        = '0;
        if ((cmd_r == CMD_INSERT || cmd_r == CMD_TEST) && item_ok) re = 1'b1;
      end
      S_INS_WAIT: begin
        wdata = rdata_sel | (WORD_BITS'(1) << vertex_r[WORD_IDX_W-1:0]);
        we0   = !ep_r;
        we1   = ep_r;
      end
      S_TEST_WAIT: begin
        res_found_nxt = rdata_sel[vertex_r[WORD_IDX_W-1:0]];
      end
      S_SCAN: begin
        re       = 1'b1;
        raddr    = scan_addr;
        rd_v_nxt = 1'b1;
        wcnt_nxt = wcnt_r + WC_W'(1);
      end
      S_DRAIN: begin
        if (!rd_v_r && !pop_v_r) begin
          if (cmd_r == CMD_COUNT) res_count_nxt = COUNT_W'(acc0_r);
          else res_support_nxt = SUPPORT_W'(sup_min);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      rd_v_r       <= 1'b0;
      pop_v_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      rd_v_r     <= rd_v_nxt;
      pop_v_r    <= rd_v_r;
      if (state_r == S_RESULT && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r    <= cmd_t'(in_tuser);
      edge_r   <= in_tdata[EDGE_W-1:0];
      ep_r     <= in_tdata[EDGE_W];
      vertex_r <= in_tdata[EDGE_W+VERTEX_W:EDGE_W+1];
    end
    wcnt_r          <= wcnt_nxt;
    acc0_r          <= acc0_nxt;
    acc1_r          <= acc1_nxt;
    accu_r          <= accu_nxt;
    pop0_r          <= pop64(cmd_r == CMD_COUNT ? rdata_sel : rdata0);
    pop1_r          <= pop64(rdata1);
    popu_r          <= pop64(rdata0 | rdata1);
    res_found_r     <= res_found_nxt;
    res_count_r     <= res_count_nxt;
    res_support_r   <= res_support_nxt;
    if (state_r == S_RESULT && out_free) begin
      out_tdata_r <= {(OUT_TDATA_W-1-COUNT_W-SUPPORT_W)'(0), res_support_r, res_count_r,
                      res_found_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_tready)
    else $error("input accepted during clearing pass");

  a_pipe_empty_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESULT |-> !rd_v_r && !pop_v_r)
    else $error("result formed before scan pipeline drained");

  a_write_only_clear_or_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (we0 || we1) |-> (state_r == S_CLEAR || state_r == S_INS_WAIT))
    else $error("bank write outside clear or insert");

  a_insert_single_bank: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS_WAIT |-> $onehot({we0, we1}))
    else $error("insert must write exactly one bank");

  a_insert_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS_WAIT |=> state_r == S_IDLE)
    else $error("insert must return to idle without a result");

endmodule
